// ----- rtl/smeu_pkg.sv -----
`default_nettype none
package smeu_pkg;

    localparam int STACK_DEPTH  = 1024;
    localparam int GLOBAL_DEPTH = 256;
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SP_W = SA_W + 1;
    localparam int GA_W = $clog2(GLOBAL_DEPTH);
    localparam int GL_W = 9;
    localparam int PC_W = 24;
    localparam int IN_W  = 64;
    localparam int OUT_W = 64;

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSHC = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_RDINT = 8'd7;
    localparam logic [7:0] OP_WRINT = 8'd8;
    localparam logic [7:0] OP_RDCHR = 8'd9;
    localparam logic [7:0] OP_WRCHR = 8'd10;
    localparam logic [7:0] OP_PUSHG = 8'd11;
    localparam logic [7:0] OP_POPG  = 8'd12;
    localparam logic [7:0] OP_ASF   = 8'd13;
    localparam logic [7:0] OP_RSF   = 8'd14;
    localparam logic [7:0] OP_PUSHL = 8'd15;
    localparam logic [7:0] OP_POPL  = 8'd16;
    localparam logic [7:0] OP_EQ    = 8'd17;
    localparam logic [7:0] OP_NE    = 8'd18;
    localparam logic [7:0] OP_LT    = 8'd19;
    localparam logic [7:0] OP_LE    = 8'd20;
    localparam logic [7:0] OP_GT    = 8'd21;
    localparam logic [7:0] OP_GE    = 8'd22;
    localparam logic [7:0] OP_JMP   = 8'd23;
    localparam logic [7:0] OP_BRF   = 8'd24;
    localparam logic [7:0] OP_BRT   = 8'd25;
    localparam logic [7:0] OP_CALL  = 8'd26;
    localparam logic [7:0] OP_RET   = 8'd27;
    localparam logic [7:0] OP_DROP  = 8'd28;
    localparam logic [7:0] OP_PUSHR = 8'd29;
    localparam logic [7:0] OP_POPR  = 8'd30;
    localparam logic [7:0] OP_DUP   = 8'd31;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_STACK = 2'd2;
    localparam logic [1:0] ST_GLOB  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_RD3, S_DIVI, S_DIV, S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic rd1;
        logic rd2;
        logic cap_b;
        logic div_init;
        logic div_step;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/smeu_ctrl.sv -----
`default_nettype none
module smeu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  smeu_pkg::t_sts     i_sts,
    output smeu_pkg::t_cmd     o_cmd,
    output logic               o_ready
);
    import smeu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.need_div) begin
                    n_state = S_DIVI;
                end else if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/smeu_dpath.sv -----
`default_nettype none
module smeu_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  smeu_pkg::t_cmd                  i_cmd,
    output smeu_pkg::t_sts                  o_sts,
    input  wire logic [smeu_pkg::IN_W-1:0]  i_in,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [smeu_pkg::GL_W-1:0]  i_cfg_wr_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [smeu_pkg::OUT_W-1:0]      o_out
);
    import smeu_pkg::*;

    logic [31:0]     r_stack [STACK_DEPTH];
    logic [31:0]     r_glob  [GLOBAL_DEPTH];
    logic [31:0]     r_rd, r_grd, r_a, r_b, r_g;
    logic [7:0]      r_op;
    logic [23:0]     r_arg;
    logic [31:0]     r_rdv;
    logic [SP_W-1:0] r_sp, r_fb;
    logic [31:0]     r_rv;
    logic [PC_W-1:0] r_pc;
    logic            r_stopped;
    logic [1:0]      r_fault;
    logic [GL_W-1:0] r_gcount;
    logic            r_o_valid;
    logic [OUT_W-1:0] r_out;
    logic [31:0]     r_q, r_ma;
    logic [32:0]     r_rem;
    logic [5:0]      r_cnt;

    logic [25:0]     sp_x, fb_x, iarg_x, idx, nsp;
    logic [SA_W-1:0] rd_addr, wr_addr;
    logic [31:0]     wr_data;
    logic            wr_en, gwr_en;
    logic [GL_W-1:0] glim;
    logic            gfault;
    logic [32:0]     rem_sh, rem_sub;
    logic [31:0]     sres, quo, rmd, div_res;
    logic [SP_W-1:0] n_sp, n_fb;
    logic [31:0]     n_rv;
    logic [PC_W-1:0] pc1, n_pc;
    logic [1:0]      fault;
    logic            n_stop, wv, wch;
    logic [31:0]     wval;

    assign sp_x   = {{(26-SP_W){1'b0}}, r_sp};
    assign fb_x   = {{(26-SP_W){1'b0}}, r_fb};
    assign iarg_x = {{2{r_arg[23]}}, r_arg};
    assign idx    = fb_x + iarg_x;
    assign nsp    = sp_x + 26'd1 + iarg_x;
    assign glim   = (r_gcount < GL_W'(GLOBAL_DEPTH)) ? r_gcount : GL_W'(GLOBAL_DEPTH);
    assign gfault = ({{(24-GL_W){1'b0}}, glim} <= r_arg);
    assign pc1    = r_pc + PC_W'(1);

    always_comb begin
        if (i_cmd.rd1) begin
            rd_addr = (r_op == OP_RSF) ? SA_W'(r_fb - SP_W'(1)) : SA_W'(r_sp - SP_W'(1));
        end else begin
            rd_addr = (r_op == OP_PUSHL) ? idx[SA_W-1:0] : SA_W'(r_sp - SP_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd1 || i_cmd.rd2) begin
            r_rd <= r_stack[rd_addr];
        end
        if (i_cmd.rd1) begin
            r_grd <= r_glob[r_arg[GA_W-1:0]];
        end
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (gwr_en) begin
            r_glob[r_arg[GA_W-1:0]] <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in[7:0];
            r_arg <= i_in[31:8];
            r_rdv <= i_in[63:32];
        end
        if (i_cmd.rd2) begin
            r_a <= r_rd;
            r_g <= r_grd;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd;
        end
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_q   <= r_b[31] ? 32'd0 - r_b : r_b;
            r_ma  <= r_a[31] ? 32'd0 - r_a : r_a;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_q   <= {r_q[30:0], !rem_sub[32]};
            r_rem <= rem_sub[32] ? rem_sh : rem_sub;
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.exec) begin
            r_out <= {3'b000, r_fault & {2{r_stopped}} | fault & {2{!r_stopped}},
                      n_stop | r_stopped, wch, wval, wv, r_stopped ? r_pc : n_pc};
        end
    end

    assign rem_sh  = {r_rem[31:0], r_q[31]};
    assign rem_sub = rem_sh - {1'b0, r_ma};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_fb      <= '0;
            r_rv      <= '0;
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_fault   <= ST_OK;
            r_gcount  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gcount <= i_cfg_wr_data;
            end
            if (i_cmd.exec && !r_stopped) begin
                r_sp      <= n_sp;
                r_fb      <= n_fb;
                r_rv      <= n_rv;
                r_pc      <= n_pc;
                r_stopped <= n_stop;
                r_fault   <= fault;
            end
            if (i_cmd.exec) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign quo     = (r_a[31] ^ r_b[31]) ? 32'd0 - r_q : r_q;
    assign rmd     = r_b[31] ? 32'd0 - r_rem[31:0] : r_rem[31:0];
    assign div_res = (r_op == OP_MOD) ? rmd : quo;

    always_comb begin
        n_sp    = r_sp;
        n_fb    = r_fb;
        n_rv    = r_rv;
        n_pc    = pc1;
        n_stop  = 1'b0;
        fault   = ST_OK;
        wv      = 1'b0;
        wch     = 1'b0;
        wval    = '0;
        wr_en   = 1'b0;
        wr_addr = r_sp[SA_W-1:0];
        wr_data = '0;
        gwr_en  = 1'b0;
        sres    = '0;
        case (r_op)
            OP_HALT: n_stop = 1'b1;
            OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR: begin
                if (r_sp == SP_W'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en = 1'b1;
                    case (r_op)
                        OP_PUSHC: wr_data = {{8{r_arg[23]}}, r_arg};
                        OP_RDINT: wr_data = r_rdv;
                        OP_RDCHR: wr_data = {24'd0, r_rdv[7:0]};
                        default:  wr_data = r_rv;
                    endcase
                    n_sp = r_sp + SP_W'(1);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
                case (r_op)
                    OP_ADD:  sres = r_b + r_a;
                    OP_SUB:  sres = r_b - r_a;
                    OP_MUL:  sres = r_b * r_a;
                    OP_EQ:   sres = {31'd0, r_b == r_a};
                    OP_NE:   sres = {31'd0, r_b != r_a};
                    OP_LT:   sres = {31'd0, $signed(r_b) <  $signed(r_a)};
                    OP_LE:   sres = {31'd0, $signed(r_b) <= $signed(r_a)};
                    OP_GT:   sres = {31'd0, $signed(r_b) >  $signed(r_a)};
                    OP_GE:   sres = {31'd0, $signed(r_b) >= $signed(r_a)};
                    default: sres = div_res;
                endcase
                if (r_sp < SP_W'(2)) begin
                    fault = ST_STACK;
                end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_a == 32'd0) begin
                    fault = ST_DIV0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = SA_W'(r_sp - SP_W'(2));
                    wr_data = sres;
                    n_sp    = r_sp - SP_W'(1);
                end
            end
            OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR: begin
                if (r_sp == '0) begin
                    fault = ST_STACK;
                end else begin
                    n_sp = r_sp - SP_W'(1);
                    case (r_op)
                        OP_WRINT: begin
                            wv   = 1'b1;
                            wval = r_a;
                        end
                        OP_WRCHR: begin
                            wv   = 1'b1;
                            wch  = 1'b1;
                            wval = {24'd0, r_a[7:0]};
                        end
                        OP_BRF:  if (r_a == 32'd0) n_pc = r_arg;
                        OP_BRT:  if (r_a != 32'd0) n_pc = r_arg;
                        OP_RET:  n_pc = r_a[PC_W-1:0];
                        default: n_rv = r_a;
                    endcase
                end
            end
            OP_PUSHG: begin
                if (gfault) begin
                    fault = ST_GLOB;
                end else if (r_sp == SP_W'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_g;
                    n_sp    = r_sp + SP_W'(1);
                end
            end
            OP_POPG: begin
                if (gfault) begin
                    fault = ST_GLOB;
                end else if (r_sp == '0) begin
                    fault = ST_STACK;
                end else begin
                    gwr_en = 1'b1;
                    n_sp   = r_sp - SP_W'(1);
                end
            end
            OP_ASF: begin
                if (r_sp == SP_W'(STACK_DEPTH) || r_arg[23] || nsp > 26'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {{(32-SP_W){1'b0}}, r_fb};
                    n_fb    = r_sp + SP_W'(1);
                    n_sp    = nsp[SP_W-1:0];
                end
            end
            OP_RSF: begin
                if (r_fb == '0 || r_fb > SP_W'(STACK_DEPTH)
                    || r_a > {{(32-SP_W){1'b0}}, r_fb - SP_W'(1)}) begin
                    fault = ST_STACK;
                end else begin
                    n_sp = r_fb - SP_W'(1);
                    n_fb = r_a[SP_W-1:0];
                end
            end
            OP_PUSHL: begin
                if (idx[25] || idx >= sp_x || r_sp == SP_W'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_b;
                    n_sp    = r_sp + SP_W'(1);
                end
            end
            OP_POPL: begin
                if (r_sp == '0 || idx[25] || idx >= sp_x - 26'd1) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = idx[SA_W-1:0];
                    wr_data = r_a;
                    n_sp    = r_sp - SP_W'(1);
                end
            end
            OP_JMP: n_pc = r_arg;
            OP_CALL: begin
                if (r_sp == SP_W'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = {8'd0, pc1};
                    n_sp    = r_sp + SP_W'(1);
                    n_pc    = r_arg;
                end
            end
            OP_DROP: begin
                if (!r_arg[23] && r_arg != 24'd0) begin
                    if (r_arg > {{(24-SP_W){1'b0}}, r_sp}) begin
                        fault = ST_STACK;
                    end else begin
                        n_sp = r_sp - r_arg[SP_W-1:0];
                    end
                end
            end
            OP_DUP: begin
                if (r_sp == '0 || r_sp == SP_W'(STACK_DEPTH)) begin
                    fault = ST_STACK;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_a;
                    n_sp    = r_sp + SP_W'(1);
                end
            end
            default: n_pc = pc1;
        endcase
        if (fault != ST_OK) begin
            n_stop = 1'b1;
            n_sp   = r_sp;
            n_fb   = r_fb;
            n_rv   = r_rv;
            n_pc   = pc1;
            wv     = 1'b0;
            wch    = 1'b0;
            wval   = '0;
            wr_en  = 1'b0;
            gwr_en = 1'b0;
        end
        if (r_stopped || !i_cmd.exec) begin
            wr_en  = 1'b0;
            gwr_en = 1'b0;
        end
        if (r_stopped) begin
            wv   = 1'b0;
            wch  = 1'b0;
            wval = '0;
        end
    end

    assign o_sts.need_div = !r_stopped && (r_op == OP_DIV || r_op == OP_MOD)
                            && r_sp >= SP_W'(2) && r_a != 32'd0 && !i_cmd.div_step
                            && r_cnt != 6'd32;
    assign o_sts.div_done = (r_cnt == 6'd31);
    assign o_sts.out_busy = r_o_valid;
    assign o_out_valid    = r_o_valid;
    assign o_out          = r_out;
endmodule
`default_nettype wire

// ----- rtl/stack_machine_execute_unit.sv -----
`default_nettype none
// Stack machine execute unit: each input item is one instruction (opcode, 24-bit immediate,
// input value) and yields one result item (next pc, output write, halted, status). The result
// is registered in the execute state; the next item can be taken in the cycle after that.
// Steps: read states RD1, RD2 and RD3 (single-port stack and global reads), then the execute
// state with writeback; div and mod add a check, a set-up state and 32 bit-serial divider
// steps. A result waits in the output register while the next item is taken; the execute
// state of that item holds until the waiting result has left. global_count is written
// through the configuration port, by the user only while the unit is idle; not enforced.
module stack_machine_execute_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // action, argument, read_value
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // next_pc, write_valid, write_value, write_is_char,
                                          // halted, status, zero fill
    input  wire logic        i_cfg_wr_en,
    input  wire logic [8:0]  i_cfg_wr_data
);
    import smeu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smeu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (o_s_tready)
    );

    smeu_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in          (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out         (o_m_tdata)
    );
endmodule
`default_nettype wire

// ----- rtl/smeu_checker.sv -----
`default_nettype none
module smeu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata
);
    logic r_seen_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_m_tvalid && i_m_tready && o_m_tdata[58]) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_seen_halt |-> o_m_tdata[58])
        else $error("halted cleared");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("accepted item while busy");

    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[60:59] != 2'd0 |-> !o_m_tdata[24] && o_m_tdata[58])
        else $error("fault without halt or with write");
endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smeu_pkg::*;

    localparam logic [7:0] OP_UNUSED = 8'd200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 380;

    typedef struct packed {
        logic [23:0] npc;
        logic        wv;
        logic [31:0] wval;
        logic        wch;
        logic        halted;
        logic [1:0]  st;
    } insn_result_t;

    typedef struct packed {
        logic [7:0]  op;
        logic [23:0] arg;
        logic [31:0] rval;
        logic        typed;
        logic [23:0] npc;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata = '0;   // action, argument, read_value
    logic        i_m_tready = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [8:0]  i_cfg_wr_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;        // next_pc, write_valid, write_value, write_is_char,
                                   // halted, status, zero fill

    stack_machine_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // machine state mirror
    logic [31:0]  stack_mem [STACK_DEPTH];
    bit           stack_set [STACK_DEPTH];
    logic [31:0]  glob_mem [GLOBAL_DEPTH];
    bit           glob_set [GLOBAL_DEPTH];
    int unsigned  sp_r = 0;
    int unsigned  fp_r = 0;
    logic [31:0]  rv_r = '0;
    logic [23:0]  pc_r = '0;
    bit           stop_r = 0;
    logic [1:0]   fault_r = ST_OK;
    int unsigned  gcount_r = 0;

    insn_result_t pending_q [$];
    int           errors = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           writes_seen = 0;
    int unsigned  cycles = 0;
    bit           idle_on = 1;
    bit           stall_on = 1;

    dir_row_t directed_rows [28] = '{
        '{OP_PUSHC, 24'h7FFFFF, 32'd0,          1'b1, 24'd1},
        '{OP_PUSHC, 24'h800000, 32'd0,          1'b0, 24'd0},
        '{OP_ADD,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_RDINT, 24'd0,      32'h80000000,   1'b0, 24'd0},
        '{OP_RDINT, 24'd0,      32'hFFFFFFFF,   1'b0, 24'd0},
        '{OP_DIV,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_DUP,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_PUSHC, 24'hFFFFFF, 32'd0,          1'b0, 24'd0},
        '{OP_MOD,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_WRINT, 24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_LT,    24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_RDCHR, 24'd0,      32'h000001FF,   1'b0, 24'd0},
        '{OP_WRCHR, 24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_POPG,  24'd3,      32'd0,          1'b0, 24'd0},
        '{OP_PUSHG, 24'd3,      32'd0,          1'b0, 24'd0},
        '{OP_ASF,   24'd2,      32'd0,          1'b0, 24'd0},
        '{OP_PUSHC, 24'd5,      32'd0,          1'b0, 24'd0},
        '{OP_POPL,  24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_PUSHL, 24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_POPR,  24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_PUSHR, 24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_CALL,  24'h000100, 32'd0,          1'b0, 24'd0},
        '{OP_RET,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_DROP,  24'd1,      32'd0,          1'b0, 24'd0},
        '{OP_RSF,   24'd0,      32'd0,          1'b0, 24'd0},
        '{OP_BRF,   24'h000123, 32'd0,          1'b0, 24'd0},
        '{OP_JMP,   24'hFFFFFF, 32'd0,          1'b1, 24'hFFFFFF},
        '{OP_UNUSED,24'd0,      32'd0,          1'b1, 24'd0}
    };

    // execute one instruction; update the mirror only when commit is set
    function automatic insn_result_t exec_insn(input logic [7:0] op, input logic [23:0] arg,
                                               input logic [31:0] rval, input bit commit,
                                               output bit unsafe);
        insn_result_t r;
        logic [31:0]  sarg, a, b, res, mb, ma, q, rm, rv_n, wval, wr_sv, wr_gv;
        longint       iarg, idx, nsp;
        int unsigned  sp, fp, glim, sp_n, fp_n, wr_si, wr_gi;
        logic [23:0]  pc;
        logic [1:0]   fault;
        bit           wv, wch, wr_s, wr_g, halt;
        unsafe = 0;
        if (stop_r) begin
            r = '{pc_r, 1'b0, 32'd0, 1'b0, 1'b1, fault_r};
            return r;
        end
        sarg = {{8{arg[23]}}, arg};
        iarg = longint'($signed(sarg));
        pc = pc_r + 24'd1;
        sp = sp_r; fp = fp_r; sp_n = sp; fp_n = fp; rv_n = rv_r;
        glim = (gcount_r < GLOBAL_DEPTH) ? gcount_r : GLOBAL_DEPTH;
        fault = ST_OK; wv = 0; wch = 0; wval = '0; wr_s = 0; wr_g = 0; halt = 0;
        wr_si = 0; wr_sv = '0; wr_gi = 0; wr_gv = '0; res = '0;
        idx = longint'(fp) + iarg;
        case (op)
            OP_HALT: halt = 1;
            OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHR: begin
                if (sp >= STACK_DEPTH) fault = ST_STACK;
                else begin
                    wr_s = 1; wr_si = sp; sp_n = sp + 1;
                    wr_sv = (op == OP_PUSHC) ? sarg : (op == OP_RDINT) ? rval :
                            (op == OP_RDCHR) ? {24'd0, rval[7:0]} : rv_r;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
                if (sp < 2) fault = ST_STACK;
                else begin
                    a = stack_mem[sp-1];
                    b = stack_mem[sp-2];
                    if (!stack_set[sp-1] || !stack_set[sp-2]) unsafe = 1;
                    case (op)
                        OP_ADD: res = b + a;
                        OP_SUB: res = b - a;
                        OP_MUL: res = b * a;
                        OP_DIV, OP_MOD: begin
                            if (a == 0) fault = ST_DIV0;
                            else begin
                                mb = b[31] ? -b : b;
                                ma = a[31] ? -a : a;
                                q = mb / ma;
                                rm = mb % ma;
                                if (op == OP_MOD) res = b[31] ? -rm : rm;
                                else res = (a[31] ^ b[31]) ? -q : q;
                            end
                        end
                        OP_EQ: res = {31'd0, b == a};
                        OP_NE: res = {31'd0, b != a};
                        OP_LT: res = {31'd0, $signed(b) < $signed(a)};
                        OP_LE: res = {31'd0, $signed(b) <= $signed(a)};
                        OP_GT: res = {31'd0, $signed(b) > $signed(a)};
                        default: res = {31'd0, $signed(b) >= $signed(a)};
                    endcase
                    if (fault == ST_OK) begin
                        wr_s = 1; wr_si = sp - 2; wr_sv = res; sp_n = sp - 1;
                    end
                end
            end
            OP_WRINT, OP_WRCHR, OP_BRF, OP_BRT, OP_RET, OP_POPR: begin
                if (sp < 1) fault = ST_STACK;
                else begin
                    a = stack_mem[sp-1];
                    if (!stack_set[sp-1]) unsafe = 1;
                    sp_n = sp - 1;
                    case (op)
                        OP_WRINT: begin wv = 1; wval = a; end
                        OP_WRCHR: begin wv = 1; wch = 1; wval = {24'd0, a[7:0]}; end
                        OP_BRF: if (a == 0) pc = arg;
                        OP_BRT: if (a != 0) pc = arg;
                        OP_RET: pc = a[23:0];
                        default: rv_n = a;
                    endcase
                end
            end
            OP_PUSHG: begin
                if (arg >= glim) fault = ST_GLOB;
                else if (sp >= STACK_DEPTH) fault = ST_STACK;
                else begin
                    if (!glob_set[arg]) unsafe = 1;
                    wr_s = 1; wr_si = sp; wr_sv = glob_mem[arg]; sp_n = sp + 1;
                end
            end
            OP_POPG: begin
                if (arg >= glim) fault = ST_GLOB;
                else if (sp < 1) fault = ST_STACK;
                else begin
                    if (!stack_set[sp-1]) unsafe = 1;
                    wr_g = 1; wr_gi = arg; wr_gv = stack_mem[sp-1]; sp_n = sp - 1;
                end
            end
            OP_ASF: begin
                nsp = longint'(sp) + 1 + iarg;
                if (sp >= STACK_DEPTH || iarg < 0 || nsp > STACK_DEPTH) fault = ST_STACK;
                else begin
                    wr_s = 1; wr_si = sp; wr_sv = fp; fp_n = sp + 1; sp_n = nsp;
                end
            end
            OP_RSF: begin
                if (fp == 0 || fp > STACK_DEPTH) fault = ST_STACK;
                else begin
                    a = stack_mem[fp-1];
                    if (!stack_set[fp-1]) unsafe = 1;
                    if (a > fp - 1) fault = ST_STACK;
                    else begin
                        sp_n = fp - 1; fp_n = a;
                    end
                end
            end
            OP_PUSHL: begin
                if (idx < 0 || idx >= sp || sp >= STACK_DEPTH) fault = ST_STACK;
                else begin
                    if (!stack_set[idx]) unsafe = 1;
                    wr_s = 1; wr_si = sp; wr_sv = stack_mem[idx]; sp_n = sp + 1;
                end
            end
            OP_POPL: begin
                if (sp < 1 || idx < 0 || idx >= longint'(sp) - 1) fault = ST_STACK;
                else begin
                    if (!stack_set[sp-1]) unsafe = 1;
                    wr_s = 1; wr_si = idx; wr_sv = stack_mem[sp-1]; sp_n = sp - 1;
                end
            end
            OP_JMP: pc = arg;
            OP_CALL: begin
                if (sp >= STACK_DEPTH) fault = ST_STACK;
                else begin
                    wr_s = 1; wr_si = sp; wr_sv = {8'd0, pc}; sp_n = sp + 1; pc = arg;
                end
            end
            OP_DROP: begin
                if (iarg > 0) begin
                    if (iarg > sp) fault = ST_STACK;
                    else sp_n = sp - iarg;
                end
            end
            OP_DUP: begin
                if (sp < 1 || sp >= STACK_DEPTH) fault = ST_STACK;
                else begin
                    if (!stack_set[sp-1]) unsafe = 1;
                    wr_s = 1; wr_si = sp; wr_sv = stack_mem[sp-1]; sp_n = sp + 1;
                end
            end
            default: ;
        endcase
        if (fault != ST_OK) begin
            pc = pc_r + 24'd1; wv = 0; wch = 0; wval = '0;
        end
        if (fault != ST_OK || halt) unsafe = 1;
        if (commit) begin
            pc_r = pc;
            if (fault != ST_OK) begin
                stop_r = 1; fault_r = fault;
            end else begin
                if (halt) stop_r = 1;
                sp_r = sp_n; fp_r = fp_n; rv_r = rv_n;
                if (wr_s) begin
                    stack_mem[wr_si] = wr_sv; stack_set[wr_si] = 1;
                end
                if (wr_g) begin
                    glob_mem[wr_gi] = wr_gv; glob_set[wr_gi] = 1;
                end
            end
        end
        r = '{pc, wv, wval, wch, (fault != ST_OK) || halt, fault};
        return r;
    endfunction

    task automatic check_result(input logic [63:0] d);
        insn_result_t want;
        results_seen++;
        if (pending_q.size() == 0) begin
            $error("result with nothing pending: %h", d);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (d[24]) writes_seen++;
        if (d[23:0] !== want.npc) begin
            $error("next_pc exp %h got %h", want.npc, d[23:0]); errors++;
        end
        if (d[24] !== want.wv) begin
            $error("write_valid exp %h got %h", want.wv, d[24]); errors++;
        end
        if (d[56:25] !== want.wval) begin
            $error("write_value exp %h got %h", want.wval, d[56:25]); errors++;
        end
        if (d[57] !== want.wch) begin
            $error("write_is_char exp %h got %h", want.wch, d[57]); errors++;
        end
        if (d[58] !== want.halted) begin
            $error("halted exp %h got %h", want.halted, d[58]); errors++;
        end
        if (d[60:59] !== want.st) begin
            $error("status exp %h got %h", want.st, d[60:59]); errors++;
        end
    endtask

    task automatic send_insn(input logic [7:0] op, input logic [23:0] arg,
                             input logic [31:0] rval, input bit typed,
                             input logic [23:0] typed_npc);
        insn_result_t pred;
        bit           dummy;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {rval, arg, op};
        do @(posedge i_clk); while (!o_s_tready);
        pred = exec_insn(op, arg, rval, 1, dummy);
        if (typed) pred = '{typed_npc, 1'b0, 32'd0, 1'b0, 1'b0, ST_OK};
        pending_q.push_back(pred);
        items_sent++;
        if (idle_on && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_gcount(input int unsigned v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v[8:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gcount_r = v;
    endtask

    // pick a random instruction that neither stops the machine nor reads an unset entry
    task automatic pick_insn(output logic [7:0] op, output logic [23:0] arg,
                             output logic [31:0] rval);
        insn_result_t dummy_r;
        bit           unsafe;
        int unsigned  glim;
        int           tries;
        glim = (gcount_r < GLOBAL_DEPTH) ? gcount_r : GLOBAL_DEPTH;
        for (tries = 0; tries < 300; tries++) begin
            op = ($urandom_range(0, 99) < 4) ? 8'($urandom_range(32, 255))
                                             : 8'($urandom_range(1, 31));
            case (op)
                OP_PUSHG, OP_POPG:
                    arg = (glim > 0) ? 24'($urandom_range(0, glim - 1)) : 24'($urandom);
                OP_ASF:  arg = 24'($urandom_range(0, 3));
                OP_DROP: arg = ($urandom_range(0, 3) == 0) ? -24'($urandom_range(0, 3))
                                                           : 24'($urandom_range(1, 3));
                OP_PUSHL, OP_POPL: arg = 24'($urandom_range(0, 6)) - 24'd2;
                default: begin
                    arg = 24'($urandom);
                    case ($urandom_range(0, 15))
                        0: arg = 24'h7FFFFF;
                        1: arg = 24'h800000;
                        2: arg = 24'hFFFFFF;
                        3: arg = 24'd0;
                        default: ;
                    endcase
                end
            endcase
            rval = $urandom;
            case ($urandom_range(0, 15))
                0: rval = 32'h80000000;
                1: rval = 32'h7FFFFFFF;
                2: rval = 32'hFFFFFFFF;
                3: rval = 32'd0;
                default: ;
            endcase
            dummy_r = exec_insn(op, arg, rval, 0, unsafe);
            if (!unsafe) return;
        end
        rval = '0;
        if (sp_r < STACK_DEPTH) begin
            op = OP_PUSHC; arg = 24'($urandom);
        end else begin
            op = OP_DROP; arg = 24'd1;
        end
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_result(o_m_tdata);
        i_m_tready <= stall_on ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned gsteps [5];
        logic [7:0]  op;
        logic [23:0] arg;
        logic [31:0] rval;
        int          stop_kind;
        gsteps = '{256, 0, 511, 1, 37};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_gcount(4);
        foreach (directed_rows[k])
            send_insn(directed_rows[k].op, directed_rows[k].arg, directed_rows[k].rval,
                      directed_rows[k].typed, directed_rows[k].npc);
        foreach (gsteps[p]) begin
            drain();
            set_gcount(gsteps[p]);
            idle_on  = (p != 2);
            stall_on = (p != 2);
            repeat (PHASE_ITEMS) begin
                pick_insn(op, arg, rval);
                send_insn(op, arg, rval, 0, '0);
            end
        end
        idle_on = 1;
        stall_on = 1;
        stop_kind = $urandom_range(0, 3);
        case (stop_kind)
            0: send_insn(OP_HALT, 24'd0, 32'd0, 0, '0);
            1: begin
                if (sp_r > STACK_DEPTH - 3) send_insn(OP_DROP, 24'd4, 32'd0, 0, '0);
                send_insn(OP_PUSHC, 24'd1, 32'd0, 0, '0);
                send_insn(OP_PUSHC, 24'd0, 32'd0, 0, '0);
                send_insn(OP_DIV, 24'd0, 32'd0, 0, '0);
            end
            2: send_insn(OP_DROP, 24'(sp_r + 1), 32'd0, 0, '0);
            default: send_insn(OP_PUSHG, 24'd300, 32'd0, 0, '0);
        endcase
        repeat (6) send_insn(8'($urandom_range(0, 255)), 24'($urandom), $urandom, 0, '0);
        drain();
        $display("%0d instructions executed, %0d results checked, %0d output writes",
                 items_sent, results_seen, writes_seen);
        $display("six global_count settings, stopped with status %0d", fault_r);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
